[hdl/cif_pkg.sv]
package cif_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 16;
    localparam int COL_OUT_W   = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_WIDTH_W = 11;
    localparam int SHIFT_W     = 4;
    localparam int KSIZE       = 3;
    localparam int WIN_CELLS   = KSIZE * KSIZE;
    localparam int COEF_W      = 8;
    localparam int PROD_W      = PIX_W + 1 + COEF_W;
    localparam int RSUM_W      = PROD_W + 2;
    localparam int SUM_W       = RSUM_W + 2;
    localparam int PTR_W       = 3;
    localparam int FIFO_DEPTH  = 1 << PTR_W;
    localparam int CNT_W       = PTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KTOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KMID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KBOT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT  = 3'd5;

    localparam logic [CFG_WIDTH_W-1:0] RST_WIDTH  = 11'd1024;
    localparam logic [ROW_W-1:0]       RST_HEIGHT = 16'hFFFF;
    localparam logic [CFG_DATA_W-1:0]  RST_KTOP   = 24'hFF0001;
    localparam logic [CFG_DATA_W-1:0]  RST_KMID   = 24'hFE0002;
    localparam logic [CFG_DATA_W-1:0]  RST_KBOT   = 24'hFF0001;
    localparam logic [SHIFT_W-1:0]     RST_SHIFT  = 4'd0;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic                 done;
    } t_meta;

    typedef struct packed {
        t_pix                 filtered;
        logic [ROW_W-1:0]     center_row;
        logic [COL_OUT_W-1:0] center_col;
        logic                 clipped;
        logic                 frame_done;
    } t_result;

    typedef struct packed {
        logic             nonempty;
        logic [CNT_W-1:0] count;
    } t_fifo_stat;

endpackage

[hdl/cif_out_fifo.sv]
module cif_out_fifo
    import cif_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_push_data,
    input  logic       i_pop,
    output t_result    o_head,
    output t_fifo_stat o_stat
);

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers wrap on their own since the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head          = r_mem[r_rd_ptr];
    assign o_stat.nonempty = (r_count != '0);
    assign o_stat.count    = r_count;

endmodule

[hdl/conv3x3_image_filter_unit.sv]
// Channel   Direction  Handshake                    Payload
// -------   ---------  ---------------------------  ------------------------------------------
// pixel     in         i_valid / o_stall            i_pixel
// result    out        o_valid / i_stall            o_filtered, o_center_row, o_center_col,
//                                                   o_clipped, o_frame_done
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One pixel request is taken per clock while o_stall is low; between its pixel and its output
// a result passes the line memory read, the window update, three arithmetic stages
// and the write into the result queue.
// The line memory is read in the accept cycle and written back in the next one.
// Reset is synchronous and active low; the line memory is not cleared.
// o_stall rises only when the result queue and the results in flight fill all eight slots.
module conv3x3_image_filter_unit
    import cif_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [PIX_W-1:0]       i_pixel,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [PIX_W-1:0]       o_filtered,
    output logic [ROW_W-1:0]       o_center_row,
    output logic [COL_OUT_W-1:0]   o_center_col,
    output logic                   o_clipped,
    output logic                   o_frame_done,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    function automatic logic [WW-1:0] clamp_width(input logic [CFG_WIDTH_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 < 32'd3) begin
            v32 = 32'd3;
        end else if (v32 > 32'(MAX_WIDTH)) begin
            v32 = 32'(MAX_WIDTH);
        end
        return WW'(v32);
    endfunction

    function automatic logic [ROW_W-1:0] clamp_height(input logic [ROW_W-1:0] v);
        return (v < 16'd3) ? 16'd3 : v;
    endfunction

    // Configuration registers, kept in their clamped form.
    logic [WW-1:0]         r_eff_w;
    logic [ROW_W-1:0]      r_eff_h;
    logic [CFG_DATA_W-1:0] r_krow [KSIZE];
    logic [SHIFT_W-1:0]    r_shift;
    logic                  cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w   <= clamp_width(RST_WIDTH);
            r_eff_h   <= clamp_height(RST_HEIGHT);
            r_krow[0] <= RST_KTOP;
            r_krow[1] <= RST_KMID;
            r_krow[2] <= RST_KBOT;
            r_shift   <= RST_SHIFT;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_eff_w   <= clamp_width(i_cfg_data[CFG_WIDTH_W-1:0]);
                REG_HEIGHT: r_eff_h   <= clamp_height(i_cfg_data[ROW_W-1:0]);
                REG_KTOP:   r_krow[0] <= i_cfg_data;
                REG_KMID:   r_krow[1] <= i_cfg_data;
                REG_KBOT:   r_krow[2] <= i_cfg_data;
                REG_SHIFT:  r_shift   <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Position counters and the accept-side bookkeeping.
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CNT_W-1:0] r_used;

    logic             acc;
    logic             wrap_pre;
    logic [ROW_W:0]   row_a;
    logic [CW-1:0]    cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [WW-1:0]    col_p1;
    logic [ROW_W:0]   row_p1;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    logic [CW-1:0]    col_m1;
    logic             is_res;
    t_meta            cur_meta;

    assign o_stall = (r_used == CNT_W'(FIFO_DEPTH));
    assign acc     = i_valid && !o_stall;

    always_comb begin
        // A size change can leave the counters outside the new frame.
        wrap_pre = (WW'(r_col) >= r_eff_w);
        cur_col  = wrap_pre ? '0 : r_col;
        row_a    = {1'b0, r_row} + {{ROW_W{1'b0}}, wrap_pre};
        cur_row  = (row_a >= {1'b0, r_eff_h}) ? '0 : row_a[ROW_W-1:0];

        col_p1 = WW'(cur_col) + WW'(1);
        row_p1 = {1'b0, cur_row} + 17'd1;
        if (col_p1 >= r_eff_w) begin
            n_col = '0;
            n_row = (row_p1 >= {1'b0, r_eff_h}) ? '0 : row_p1[ROW_W-1:0];
        end else begin
            n_col = col_p1[CW-1:0];
            n_row = cur_row;
        end

        col_m1        = cur_col - CW'(1);
        is_res        = (cur_row >= 16'd2) && (cur_col >= CW'(2));
        cur_meta.row  = cur_row - 16'd1;
        cur_meta.col  = COL_OUT_W'(col_m1);
        cur_meta.done = (cur_row == r_eff_h - 16'd1) && (WW'(cur_col) == r_eff_w - WW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line memory: entry c holds {row above above, row above} for column c.
    logic [2*PIX_W-1:0] r_line [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;
    logic               r_s1_vld;
    t_pix               r_s1_px;
    logic [CW-1:0]      r_s1_col;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd <= r_line[cur_col];
        end
    end

    // Consecutive pixels never share a column, so the write-back cannot collide.
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_line[r_s1_col] <= {r_rd[PIX_W-1:0], r_s1_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_px  <= i_pixel;
            r_s1_col <= cur_col;
        end
    end

    // Result flags and positions travel alongside the arithmetic.
    logic [5:1] r_res;
    t_meta      r_meta [1:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= {r_res[4:1], acc && is_res};
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta[1] <= cur_meta;
        for (int i = 2; i <= 5; i++) begin
            r_meta[i] <= r_meta[i-1];
        end
    end

    // 3x3 window; the newest column enters on the right.
    t_pix r_win [WIN_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_CELLS; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_vld) begin
            for (int k = 0; k < KSIZE; k++) begin
                r_win[k*KSIZE]     <= r_win[k*KSIZE + 1];
                r_win[k*KSIZE + 1] <= r_win[k*KSIZE + 2];
            end
            r_win[2]           <= r_rd[2*PIX_W-1:PIX_W];
            r_win[KSIZE + 2]   <= r_rd[PIX_W-1:0];
            r_win[2*KSIZE + 2] <= r_s1_px;
        end
    end

    logic signed [COEF_W-1:0] coef [WIN_CELLS];
    logic signed [PROD_W-1:0] r_prod [WIN_CELLS];
    logic signed [RSUM_W-1:0] r_rsum [KSIZE];
    logic signed [SUM_W-1:0]  r_sum;

    always_comb begin
        for (int kr = 0; kr < KSIZE; kr++) begin
            for (int kc = 0; kc < KSIZE; kc++) begin
                coef[kr*KSIZE + kc] = r_krow[kr][kc*COEF_W +: COEF_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < WIN_CELLS; i++) begin
            r_prod[i] <= $signed({{(PROD_W-PIX_W){1'b0}}, r_win[i]})
                       * $signed({{(PROD_W-COEF_W){coef[i][COEF_W-1]}}, coef[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < KSIZE; k++) begin
            r_rsum[k] <= RSUM_W'(r_prod[k*KSIZE]) + RSUM_W'(r_prod[k*KSIZE + 1])
                       + RSUM_W'(r_prod[k*KSIZE + 2]);
        end
        r_sum <= SUM_W'(r_rsum[0]) + SUM_W'(r_rsum[1]) + SUM_W'(r_rsum[2]);
    end

    // Scale toward zero and saturate.
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] shifted;
    t_result          push_data;

    always_comb begin
        mag     = r_sum[SUM_W-1] ? $unsigned(-r_sum) : $unsigned(r_sum);
        shifted = mag >> r_shift;
        if (r_sum[SUM_W-1]) begin
            push_data.filtered = '0;
            push_data.clipped  = (shifted != '0);
        end else if (shifted > SUM_W'(255)) begin
            push_data.filtered = '1;
            push_data.clipped  = 1'b1;
        end else begin
            push_data.filtered = shifted[PIX_W-1:0];
            push_data.clipped  = 1'b0;
        end
        push_data.center_row = r_meta[5].row;
        push_data.center_col = r_meta[5].col;
        push_data.frame_done = r_meta[5].done;
    end

    t_result    head;
    t_fifo_stat fifo_stat;
    logic       pop;

    cif_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_res[5]),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (fifo_stat)
    );

    assign o_valid      = fifo_stat.nonempty;
    assign pop          = o_valid && !i_stall;
    assign o_filtered   = head.filtered;
    assign o_center_row = head.center_row;
    assign o_center_col = head.center_col;
    assign o_clipped    = head.clipped;
    assign o_frame_done = head.frame_done;

    // Slots are reserved when a pixel that will give a result is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            case ({acc && is_res, pop})
                2'b10:   r_used <= r_used + CNT_W'(1);
                2'b01:   r_used <= r_used - CNT_W'(1);
                default: r_used <= r_used;
            endcase
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(FIFO_DEPTH))
        else $error("result slot reservation exceeds queue depth");

    a_queue_within_reservation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.count <= r_used)
        else $error("result queue holds more entries than reserved");

    a_line_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_s1_vld) |-> (cur_col != r_s1_col))
        else $error("line memory read and write-back hit the same column");

endmodule

[tb/tb_conv3x3_image_filter_unit.sv]
`timescale 1ns / 1ps

module tb_conv3x3_image_filter_unit;
    import cif_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int PIPE_SLACK   = 12;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 200;

    // Indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam t_pix PIX_BLACK = '0;
    localparam t_pix PIX_WHITE = '1;

    localparam logic [CFG_DATA_W-1:0] KROW_ZERO       = 24'h000000;
    localparam logic [CFG_DATA_W-1:0] KROW_MOST_NEG   = 24'h808080;
    localparam logic [CFG_DATA_W-1:0] KROW_MOST_POS   = 24'h7F7F7F;
    localparam logic [CFG_DATA_W-1:0] KROW_NEG_CENTER = 24'h00FF00;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [PIX_W-1:0]       i_pixel = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [PIX_W-1:0]       o_filtered;
    logic [ROW_W-1:0]       o_center_row;
    logic [COL_OUT_W-1:0]   o_center_col;
    logic                   o_clipped;
    logic                   o_frame_done;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    conv3x3_image_filter_unit #(
        .MAX_WIDTH(MAX_W)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_pixel(i_pixel),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_filtered(o_filtered),
        .o_center_row(o_center_row),
        .o_center_col(o_center_col),
        .o_clipped(o_clipped),
        .o_frame_done(o_frame_done),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Filter state mirrored in the testbench.
    logic [CFG_WIDTH_W-1:0] cfg_width  = RST_WIDTH;
    logic [ROW_W-1:0]       cfg_height = RST_HEIGHT;
    logic [CFG_DATA_W-1:0]  kernel_rows [KSIZE] = '{RST_KTOP, RST_KMID, RST_KBOT};
    logic [SHIFT_W-1:0]     cfg_shift  = RST_SHIFT;
    t_pix                   line_mem [2*MAX_W] = '{default: '0};
    t_pix                   window [KSIZE][KSIZE] = '{default: '{default: '0}};
    int unsigned            col_pos = 0;
    int unsigned            row_pos = 0;

    t_result     pending_results [$];
    int unsigned pixels_sent = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct = 15;
    int unsigned recv_idle_pct = 69;
    int unsigned stall_hold_left = 0;

    function automatic int unsigned used_width();
        if (cfg_width < 3) return 3;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    function automatic int unsigned used_height();
        return (cfg_height < 3) ? 3 : cfg_height;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WIDTH:  cfg_width = data[CFG_WIDTH_W-1:0];
            REG_HEIGHT: cfg_height = data[ROW_W-1:0];
            REG_KTOP:   kernel_rows[0] = data;
            REG_KMID:   kernel_rows[1] = data;
            REG_KBOT:   kernel_rows[2] = data;
            REG_SHIFT:  cfg_shift = data[SHIFT_W-1:0];
            default: ;
        endcase
    endfunction

    // True when the next pixel lands on row 0, column 0 under the current size.
    function automatic bit at_frame_start();
        int unsigned c;
        int unsigned r;
        c = col_pos;
        r = row_pos;
        if (c >= used_width()) begin
            c = 0;
            r++;
        end
        if (r >= used_height()) r = 0;
        return (c == 0) && (r == 0);
    endfunction

    function automatic void filter_pixel(input t_pix px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        t_pix        top;
        t_pix        mid;
        int          acc;
        int          pix_val;
        byte         coef;
        int          quot;
        t_result     res;
        w = used_width();
        h = used_height();
        // A size written mid-frame takes effect here, on the next pixel.
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;

        top = line_mem[MAX_W + c];
        mid = line_mem[c];
        line_mem[MAX_W + c] = mid;
        line_mem[c] = px;

        for (int kr = 0; kr < KSIZE; kr++) begin
            window[kr][0] = window[kr][1];
            window[kr][1] = window[kr][2];
        end
        window[0][2] = top;
        window[1][2] = mid;
        window[2][2] = px;

        if (r >= 2 && c >= 2) begin
            acc = 0;
            for (int kr = 0; kr < KSIZE; kr++) begin
                for (int kc = 0; kc < KSIZE; kc++) begin
                    pix_val = window[kr][kc];
                    coef = kernel_rows[kr][8*kc +: 8];
                    acc += pix_val * coef;
                end
            end
            // The division truncates toward zero, so small negative sums become zero.
            if (acc < 0) quot = -((-acc) >> cfg_shift);
            else quot = acc >> cfg_shift;
            if (quot < 0) begin
                res.filtered = '0;
                res.clipped = 1'b1;
            end else if (quot > 255) begin
                res.filtered = '1;
                res.clipped = 1'b1;
            end else begin
                res.filtered = t_pix'(quot);
                res.clipped = 1'b0;
            end
            res.center_row = ROW_W'(r - 1);
            res.center_col = COL_OUT_W'(c - 1);
            res.frame_done = (r == h - 1) && (c == w - 1);
            pending_results.push_back(res);
        end

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    function automatic t_pix rand_pixel();
        case ($urandom_range(7))
            0: return PIX_BLACK;
            1: return PIX_WHITE;
            default: return t_pix'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_krow();
        logic [CFG_DATA_W-1:0] bits;
        for (int b = 0; b < KSIZE; b++) begin
            if ($urandom_range(3) == 0) bits[8*b +: 8] = 8'($urandom_range(255));
            else bits[8*b +: 8] = 8'(int'($urandom_range(8)) - 4);
        end
        return bits;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_shift();
        if ($urandom_range(1) == 0) return CFG_DATA_W'($urandom_range(2, 7));
        return CFG_DATA_W'($urandom_range(15));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_width();
        case ($urandom_range(7))
            0: return CFG_DATA_W'($urandom_range(2));
            1: return CFG_DATA_W'($urandom_range(17, 64));
            default: return CFG_DATA_W'($urandom_range(3, 16));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_height();
        if ($urandom_range(7) == 0) return CFG_DATA_W'($urandom_range(2));
        return CFG_DATA_W'($urandom_range(3, 8));
    endfunction

    // Pixel requests: the prediction is made at the edge that takes the request.
    task automatic send_pixel(input t_pix px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        filter_pixel(px);
        pixels_sent++;
    endtask

    task automatic finish_frame();
        while (!at_frame_start()) send_pixel(rand_pixel());
    endtask

    task automatic send_frame();
        send_pixel(rand_pixel());
        finish_frame();
    endtask

    // Border pixels give no result but still sit in the pipeline, hence the slack.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    task automatic cfg_release();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_setup(input logic [CFG_DATA_W-1:0] width,
                              input logic [CFG_DATA_W-1:0] height,
                              input logic [CFG_DATA_W-1:0] ktop,
                              input logic [CFG_DATA_W-1:0] kmid,
                              input logic [CFG_DATA_W-1:0] kbot,
                              input logic [CFG_DATA_W-1:0] shift);
        drain();
        write_reg(REG_WIDTH, width);
        write_reg(REG_HEIGHT, height);
        write_reg(REG_KTOP, ktop);
        write_reg(REG_KMID, kmid);
        write_reg(REG_KBOT, kbot);
        write_reg(REG_SHIFT, shift);
        cfg_release();
    endtask

    // Reset kernel and height, narrow rows, full-scale pixels on both sides.
    task automatic test_border_and_reset_kernel();
        write_reg(REG_WIDTH, CFG_DATA_W'(5));
        cfg_release();
        for (int i = 0; i < 19; i++) begin
            send_pixel(((i % 4) < 2) ? PIX_WHITE : PIX_BLACK);
        end
    endtask

    // The stream stands at row 3, column 4 of a five-wide frame here.
    task automatic test_size_change_mid_frame();
        drain();
        write_reg(REG_WIDTH, CFG_DATA_W'(3));
        cfg_release();
        repeat (3) send_pixel(rand_pixel());
        drain();
        write_reg(REG_HEIGHT, CFG_DATA_W'(1));
        cfg_release();
    endtask

    task automatic test_kernel_extremes();
        load_setup(CFG_DATA_W'(3), CFG_DATA_W'(3),
                   KROW_MOST_NEG, KROW_MOST_NEG, KROW_MOST_NEG, CFG_DATA_W'(0));
        repeat (9) send_pixel(PIX_WHITE);

        load_setup(CFG_DATA_W'(3), CFG_DATA_W'(3),
                   KROW_MOST_POS, KROW_MOST_POS, KROW_MOST_POS, CFG_DATA_W'(15));
        @(posedge i_clk);
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        cfg_release();
        repeat (9) send_pixel(PIX_WHITE);

        // A sum of -15 shifted by 4 must give zero without a clip.
        load_setup(CFG_DATA_W'(3), CFG_DATA_W'(3),
                   KROW_ZERO, KROW_NEG_CENTER, KROW_ZERO, CFG_DATA_W'(4));
        repeat (9) send_pixel(t_pix'(15));
    endtask

    task automatic test_random_frames();
        int unsigned goal;
        int unsigned frame_len;
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 69;
                end
                1: begin
                    send_idle_pct = 69;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            goal = pixels_sent + RANDOM_ITEMS / 3;
            while (pixels_sent < goal) begin
                load_setup(rand_width(), rand_height(), rand_krow(), rand_krow(),
                           rand_krow(), rand_shift());
                if ($urandom_range(3) == 0) begin
                    // Retune the top and middle kernel rows and the shift partway through a frame.
                    frame_len = used_width() * used_height();
                    repeat ($urandom_range(1, frame_len - 1)) send_pixel(rand_pixel());
                    drain();
                    write_reg(REG_KTOP, rand_krow());
                    write_reg(REG_KMID, rand_krow());
                    write_reg(REG_SHIFT, rand_shift());
                    cfg_release();
                    finish_frame();
                end else begin
                    repeat ($urandom_range(1, 2)) send_frame();
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        load_setup(CFG_DATA_W'(10), CFG_DATA_W'(6), rand_krow(), rand_krow(),
                   rand_krow(), rand_shift());
        stall_hold_left = HOLD_CYCLES;
        send_frame();
    endtask

    // Width above the maximum is used as the maximum; height 0 is used as 3.
    task automatic test_widest_frame();
        load_setup(CFG_DATA_W'(2047), CFG_DATA_W'(0), rand_krow(), rand_krow(),
                   rand_krow(), rand_shift());
        send_frame();
    endtask

    always @(posedge i_clk) begin
        if (stall_hold_left > 0) begin
            stall_hold_left = stall_hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result request with no expected result pending");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_filtered !== want.filtered) begin
                    $error("filtered: expected %0d, got %0d", want.filtered, o_filtered);
                    mismatch_count++;
                end
                if (o_center_row !== want.center_row) begin
                    $error("center_row: expected %0d, got %0d", want.center_row, o_center_row);
                    mismatch_count++;
                end
                if (o_center_col !== want.center_col) begin
                    $error("center_col: expected %0d, got %0d", want.center_col, o_center_col);
                    mismatch_count++;
                end
                if (o_clipped !== want.clipped) begin
                    $error("clipped: expected %0d, got %0d", want.clipped, o_clipped);
                    mismatch_count++;
                end
                if (o_frame_done !== want.frame_done) begin
                    $error("frame_done: expected %0d, got %0d", want.frame_done, o_frame_done);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_border_and_reset_kernel();
        test_size_change_mid_frame();
        test_kernel_extremes();
        test_random_frames();
        test_output_backpressure();
        test_widest_frame();
        drain();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
